### rtl/cartesian_to_frenet_unit_macros.svh
// ----------------------------------------------------------------------------
// Cartesian to Frenet unit assertion macros
// Concurrent checks on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef CARTESIAN_TO_FRENET_UNIT_MACROS_SVH
`define CARTESIAN_TO_FRENET_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define C2F_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define C2F_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define C2F_ASSERT(label, prop, msg)
`define C2F_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

### rtl/c2f_pkg.sv
// ----------------------------------------------------------------------------
// Cartesian to Frenet package
// Beat types, register indexes, constants and arithmetic helpers.
// ----------------------------------------------------------------------------
package c2f_pkg;

  localparam int WAYPOINTS_DEF = 256;

  localparam logic [1:0] REG_WAYPOINT_COUNT = 2'd0;
  localparam logic [1:0] REG_CENTRE_X       = 2'd1;
  localparam logic [1:0] REG_CENTRE_Y       = 2'd2;

  localparam logic [8:0]  COUNT_RESET    = 9'd2;
  localparam logic [31:0] CENTRE_X_RESET = 32'd1024000;
  localparam logic [31:0] CENTRE_Y_RESET = 32'd2048000;

  localparam logic [32:0] NEAR_LIM    = 33'd102400000;
  localparam logic [55:0] NEAR_SQ     = 56'd10485760000000000;
  localparam logic [39:0] S_MAX       = 40'hFF_FFFF_FFFF;
  localparam logic [31:0] NORM_LIM    = 32'd268435456;

  typedef struct packed {
    logic              operation;
    logic [7:0]        entry_index;
    logic signed [31:0] entry_x;
    logic signed [31:0] entry_y;
    logic signed [31:0] query_x;
    logic signed [31:0] query_y;
    logic signed [15:0] query_heading;
  } c2f_req_t;

  typedef struct packed {
    logic [39:0]        path_s;
    logic signed [39:0] lateral_d;
    logic [7:0]         next_index;
    logic [7:0]         prev_index;
  } c2f_res_t;

  function automatic logic [13:0] atan_entry(input logic [3:0] i);
    logic [13:0] v;
    case (i)
      4'd0:    v = 14'd8192;
      4'd1:    v = 14'd4836;
      4'd2:    v = 14'd2555;
      4'd3:    v = 14'd1297;
      4'd4:    v = 14'd651;
      4'd5:    v = 14'd326;
      4'd6:    v = 14'd163;
      4'd7:    v = 14'd81;
      4'd8:    v = 14'd41;
      4'd9:    v = 14'd20;
      4'd10:   v = 14'd10;
      4'd11:   v = 14'd5;
      4'd12:   v = 14'd3;
      4'd13:   v = 14'd1;
      4'd14:   v = 14'd1;
      default: v = 14'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [30:0] sat_diff(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
    logic signed [32:0] d;
    d = 33'(a) - 33'(b);
    if (d > 33'sd536870912) return 31'sd536870912;
    if (d < -33'sd536870912) return -31'sd536870912;
    return 31'(d);
  endfunction

  function automatic logic [31:0] mag34(input logic signed [33:0] v);
    return 32'((v < 0) ? -v : v);
  endfunction

endpackage

### rtl/c2f_ram.sv
// ----------------------------------------------------------------------------
// Cartesian to Frenet waypoint RAM
// Single port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module c2f_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### rtl/cartesian_to_frenet_unit.sv
// A query runs from the start beat to the done beat; its length grows with N, the
// waypoints in use, and with P, the segment start index; a zero bearing vector
// or a zero-length segment skips work. The two projection divides, the square root
// unit and the path length sum set most of it.
// One query at a time; busy is high. A waypoint write leaves busy low; done marks
// the result for one cycle. Reset loads register defaults, returns to idle and clears done.
// ----------------------------------------------------------------------------
// Cartesian to Frenet conversion unit
// Nearest waypoint search, CORDIC bearing, segment projection and path length.
// ----------------------------------------------------------------------------
`include "cartesian_to_frenet_unit_macros.svh"

module cartesian_to_frenet_unit #(
  parameter int WAYPOINTS = c2f_pkg::WAYPOINTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  c2f_pkg::c2f_req_t  request,
  output logic               done,
  output c2f_pkg::c2f_res_t  result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int AW  = $clog2(WAYPOINTS);
  localparam int CW  = $clog2(WAYPOINTS + 1);
  localparam int CW1 = CW + 1;

  typedef enum logic [33:0] {
    S_IDLE  = 34'b1 << 0,  S_NRD  = 34'b1 << 1,  S_NDX  = 34'b1 << 2,
    S_NSQ1  = 34'b1 << 3,  S_NSQ2 = 34'b1 << 4,  S_BRD  = 34'b1 << 5,
    S_BLD   = 34'b1 << 6,  S_BNORM = 34'b1 << 7, S_BCOR = 34'b1 << 8,
    S_BDEC  = 34'b1 << 9,  S_PRD  = 34'b1 << 10, S_PLD  = 34'b1 << 11,
    S_XLD   = 34'b1 << 12, S_DOT1 = 34'b1 << 13, S_DOT2 = 34'b1 << 14,
    S_NNE   = 34'b1 << 15, S_PM1  = 34'b1 << 16, S_PM2  = 34'b1 << 17,
    S_DVI   = 34'b1 << 18, S_DIV  = 34'b1 << 19, S_PRJ  = 34'b1 << 20,
    S_SQA   = 34'b1 << 21, S_SQB  = 34'b1 << 22, S_RT   = 34'b1 << 23,
    S_DL    = 34'b1 << 24, S_CA   = 34'b1 << 25, S_CB   = 34'b1 << 26,
    S_PL    = 34'b1 << 27, S_SRD0 = 34'b1 << 28, S_SLD0 = 34'b1 << 29,
    S_SRD   = 34'b1 << 30, S_SLD  = 34'b1 << 31, S_SACC = 34'b1 << 32,
    S_FIN   = 34'b1 << 33
  } state_t;

  state_t state, sq_ret, rt_ret;

  logic [8:0]         waypoint_count;
  logic signed [31:0] centre_x, centre_y;

  logic [CW-1:0]      cnt, k, best_idx, nxt, prv;
  logic signed [31:0] qx, qy;
  logic signed [15:0] th;
  logic [55:0]        best, nsq;
  logic [26:0]        nax, nay;
  logic               nskip;

  logic signed [33:0] cor_x, cor_y;
  logic signed [17:0] cor_z;
  logic [3:0]         cor_i;

  logic signed [31:0] wpx, wpy, lastx, lasty;
  logic signed [30:0] nx, ny, xx, xy, ccx, ccy;
  logic signed [60:0] dot;
  logic [59:0]        nn;
  logic [89:0]        prod;
  logic               comp;
  logic [60:0]        dv_rem;
  logic [31:0]        dv_lo, dv_q;
  logic [4:0]         dv_cnt;
  logic signed [32:0] px, py;

  logic signed [33:0] ea, eb;
  logic [63:0]        sum2, ca;
  logic [33:0]        rt_rem;
  logic [31:0]        rt_root, dlen, plen;
  logic [4:0]         rt_cnt;
  logic               dneg;
  logic [39:0]        s;

  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic [63:0]        ram_rdata;
  logic signed [31:0] rd_x, rd_y;

  logic [31:0]        mul_a, mul_b;
  logic [63:0]        mul_p;

  logic [CW-1:0]      cnt_c, nxt_c, prv_c;
  logic signed [18:0] diff_c, adiff_c;
  logic [CW1-1:0]     cand_c;
  logic signed [32:0] ndx_c, ndy_c;
  logic [32:0]        nax_c, nay_c;
  logic [55:0]        dd_c;
  logic [59:0]        dot_mag;
  logic signed [30:0] n_c;
  logic [31:0]        nmag;
  logic [61:0]        rem2_c;
  logic               dv_ge;
  logic signed [32:0] proj_c;
  logic [35:0]        rt_rem_s, rt_trial;
  logic               rt_ge;
  logic signed [33:0] cxs, cys;
  logic [17:0]        tab_c;
  logic [40:0]        s_acc_c, s_fin_c;
  logic               query_go;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);
  assign rd_x      = $signed(ram_rdata[63:32]);
  assign rd_y      = $signed(ram_rdata[31:0]);
  assign mul_p     = 64'(mul_a) * 64'(mul_b);
  assign query_go  = start && !busy && request.operation;

  c2f_ram #(.WIDTH(64), .DEPTH(WAYPOINTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata ({request.entry_x, request.entry_y}),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (waypoint_count < 9'd2) begin
      cnt_c = CW'(2);
    end else if (32'(waypoint_count) > WAYPOINTS) begin
      cnt_c = CW'(WAYPOINTS);
    end else begin
      cnt_c = CW'(waypoint_count);
    end
    diff_c  = 19'(th) - 19'(cor_z);
    adiff_c = (diff_c < 0) ? -diff_c : diff_c;
    cand_c  = (adiff_c > 19'sd8192) ? CW1'(best_idx) + CW1'(1) : CW1'(best_idx);
    nxt_c   = (cand_c >= CW1'(cnt)) ? '0 : CW'(cand_c);
    prv_c   = (nxt_c == '0) ? CW'(cnt - CW'(1)) : CW'(nxt_c - CW'(1));
    ndx_c   = 33'(rd_x) - 33'(qx);
    ndy_c   = 33'(rd_y) - 33'(qy);
    nax_c   = 33'((ndx_c < 0) ? -ndx_c : ndx_c);
    nay_c   = 33'((ndy_c < 0) ? -ndy_c : ndy_c);
    dd_c    = nsq + 56'(mul_p);
    dot_mag = 60'((dot < 0) ? -dot : dot);
    n_c     = comp ? ny : nx;
    nmag    = c2f_pkg::mag34(34'(n_c));
    rem2_c  = {dv_rem, dv_lo[31]};
    dv_ge   = (rem2_c >= 62'(nn));
    proj_c  = ((dot < 0) != (n_c < 0)) ? -33'(dv_q) : 33'(dv_q);
    rt_rem_s = {rt_rem, sum2[63:62]};
    rt_trial = 36'({rt_root, 2'b01});
    rt_ge    = (rt_rem_s >= rt_trial);
    cxs      = 34'(cor_x) >>> cor_i;
    cys      = 34'(cor_y) >>> cor_i;
    tab_c    = 18'(c2f_pkg::atan_entry(cor_i));
    s_acc_c  = 41'(s) + 41'(rt_root);
    s_fin_c  = 41'(s) + 41'(plen);
  end

  always_comb begin
    ram_we   = 1'b0;
    ram_addr = '0;
    case (state)
      S_IDLE: begin
        ram_we   = start && !request.operation && (32'(request.entry_index) < WAYPOINTS);
        ram_addr = AW'(request.entry_index);
      end
      S_NRD:   ram_addr = k[AW-1:0];
      S_BRD:   ram_addr = best_idx[AW-1:0];
      S_PRD:   ram_addr = prv[AW-1:0];
      S_PLD:   ram_addr = nxt[AW-1:0];
      S_SRD:   ram_addr = k[AW-1:0];
      default: ram_addr = '0;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_NSQ1: begin mul_a = 32'(nax); mul_b = 32'(nax); end
      S_NSQ2: begin mul_a = 32'(nay); mul_b = 32'(nay); end
      S_DOT1: begin
        mul_a = c2f_pkg::mag34(34'(xx));
        mul_b = c2f_pkg::mag34(34'(nx));
      end
      S_DOT2: begin
        mul_a = c2f_pkg::mag34(34'(xy));
        mul_b = c2f_pkg::mag34(34'(ny));
      end
      S_PM1:  begin mul_a = 32'(dot_mag[29:0]);  mul_b = nmag; end
      S_PM2:  begin mul_a = 32'(dot_mag[59:30]); mul_b = nmag; end
      S_SQA:  begin mul_a = c2f_pkg::mag34(ea); mul_b = c2f_pkg::mag34(ea); end
      S_SQB:  begin mul_a = c2f_pkg::mag34(eb); mul_b = c2f_pkg::mag34(eb); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      waypoint_count <= c2f_pkg::COUNT_RESET;
      centre_x       <= $signed(c2f_pkg::CENTRE_X_RESET);
      centre_y       <= $signed(c2f_pkg::CENTRE_Y_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        c2f_pkg::REG_WAYPOINT_COUNT: waypoint_count <= cfg_data[8:0];
        c2f_pkg::REG_CENTRE_X:       centre_x <= $signed(cfg_data);
        c2f_pkg::REG_CENTRE_Y:       centre_y <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (query_go) begin
            qx       <= request.query_x;
            qy       <= request.query_y;
            th       <= request.query_heading;
            cnt      <= cnt_c;
            k        <= '0;
            best     <= c2f_pkg::NEAR_SQ;
            best_idx <= '0;
            state    <= S_NRD;
          end
        end
        S_NRD: state <= S_NDX;
        S_NDX: begin
          nax   <= 27'(nax_c);
          nay   <= 27'(nay_c);
          nskip <= (nax_c >= c2f_pkg::NEAR_LIM) || (nay_c >= c2f_pkg::NEAR_LIM);
          state <= S_NSQ1;
        end
        S_NSQ1: begin
          nsq   <= 56'(mul_p);
          state <= S_NSQ2;
        end
        S_NSQ2: begin
          if (!nskip && dd_c < best) begin
            best     <= dd_c;
            best_idx <= k;
          end
          if (CW'(k + CW'(1)) == cnt) begin
            state <= S_BRD;
          end else begin
            k     <= CW'(k + CW'(1));
            state <= S_NRD;
          end
        end
        S_BRD: state <= S_BLD;
        S_BLD: begin
          if (c2f_pkg::sat_diff(rd_x, qx) == '0 && c2f_pkg::sat_diff(rd_y, qy) == '0) begin
            cor_z <= '0;
            state <= S_BDEC;
          end else if (c2f_pkg::sat_diff(rd_x, qx) < 0) begin
            cor_z <= (c2f_pkg::sat_diff(rd_y, qy) >= 0) ? 18'sd32768 : -18'sd32768;
            cor_x <= -34'(c2f_pkg::sat_diff(rd_x, qx));
            cor_y <= -34'(c2f_pkg::sat_diff(rd_y, qy));
            state <= S_BNORM;
          end else begin
            cor_z <= '0;
            cor_x <= 34'(c2f_pkg::sat_diff(rd_x, qx));
            cor_y <= 34'(c2f_pkg::sat_diff(rd_y, qy));
            state <= S_BNORM;
          end
        end
        S_BNORM: begin
          if (c2f_pkg::mag34(cor_x) < c2f_pkg::NORM_LIM &&
              c2f_pkg::mag34(cor_y) < c2f_pkg::NORM_LIM) begin
            cor_x <= cor_x <<< 1;
            cor_y <= cor_y <<< 1;
          end else begin
            cor_i <= '0;
            state <= S_BCOR;
          end
        end
        S_BCOR: begin
          if (cor_y > 0) begin
            cor_x <= cor_x + cys;
            cor_y <= cor_y - cxs;
            cor_z <= cor_z + $signed(tab_c);
          end else begin
            cor_x <= cor_x - cys;
            cor_y <= cor_y + cxs;
            cor_z <= cor_z - $signed(tab_c);
          end
          cor_i <= cor_i + 4'd1;
          if (cor_i == 4'd15) begin
            state <= S_BDEC;
          end
        end
        S_BDEC: begin
          nxt   <= nxt_c;
          prv   <= prv_c;
          state <= S_PRD;
        end
        S_PRD: state <= S_PLD;
        S_PLD: begin
          wpx   <= rd_x;
          wpy   <= rd_y;
          state <= S_XLD;
        end
        S_XLD: begin
          nx    <= c2f_pkg::sat_diff(rd_x, wpx);
          ny    <= c2f_pkg::sat_diff(rd_y, wpy);
          xx    <= c2f_pkg::sat_diff(qx, wpx);
          xy    <= c2f_pkg::sat_diff(qy, wpy);
          ccx   <= c2f_pkg::sat_diff(centre_x, wpx);
          ccy   <= c2f_pkg::sat_diff(centre_y, wpy);
          state <= S_DOT1;
        end
        S_DOT1: begin
          dot   <= ((xx < 0) != (nx < 0)) ? -$signed(61'(mul_p)) : $signed(61'(mul_p));
          state <= S_DOT2;
        end
        S_DOT2: begin
          dot    <= ((xy < 0) != (ny < 0)) ? dot - $signed(61'(mul_p))
                                            : dot + $signed(61'(mul_p));
          ea     <= 34'(nx);
          eb     <= 34'(ny);
          sq_ret <= S_NNE;
          state  <= S_SQA;
        end
        S_NNE: begin
          nn <= 60'(sum2);
          if (sum2 == '0) begin
            px     <= '0;
            py     <= '0;
            ea     <= 34'(xx);
            eb     <= 34'(xy);
            sq_ret <= S_RT;
            rt_ret <= S_DL;
            state  <= S_SQA;
          end else begin
            comp  <= 1'b0;
            state <= S_PM1;
          end
        end
        S_PM1: begin
          prod  <= 90'(mul_p);
          state <= S_PM2;
        end
        S_PM2: begin
          prod  <= prod + (90'(mul_p) << 30);
          state <= S_DVI;
        end
        S_DVI: begin
          dv_rem <= 61'(prod[89:32]);
          dv_lo  <= prod[31:0];
          dv_q   <= '0;
          dv_cnt <= '0;
          state  <= S_DIV;
        end
        S_DIV: begin
          dv_rem <= dv_ge ? 61'(rem2_c - 62'(nn)) : 61'(rem2_c);
          dv_lo  <= dv_lo << 1;
          dv_q   <= {dv_q[30:0], dv_ge};
          dv_cnt <= dv_cnt + 5'd1;
          if (dv_cnt == 5'd31) begin
            state <= S_PRJ;
          end
        end
        S_PRJ: begin
          if (!comp) begin
            px    <= proj_c;
            comp  <= 1'b1;
            state <= S_PM1;
          end else begin
            py     <= proj_c;
            ea     <= 34'(xx) - 34'(px);
            eb     <= 34'(xy) - 34'(proj_c);
            sq_ret <= S_RT;
            rt_ret <= S_DL;
            state  <= S_SQA;
          end
        end
        S_SQA: begin
          sum2    <= mul_p;
          rt_rem  <= '0;
          rt_root <= '0;
          rt_cnt  <= '0;
          state   <= S_SQB;
        end
        S_SQB: begin
          sum2  <= sum2 + mul_p;
          state <= sq_ret;
        end
        S_RT: begin
          rt_rem  <= rt_ge ? 34'(rt_rem_s - rt_trial) : 34'(rt_rem_s);
          rt_root <= {rt_root[30:0], rt_ge};
          sum2    <= sum2 << 2;
          rt_cnt  <= rt_cnt + 5'd1;
          if (rt_cnt == 5'd31) begin
            state <= rt_ret;
          end
        end
        S_DL: begin
          dlen   <= rt_root;
          ea     <= 34'(ccx) - 34'(xx);
          eb     <= 34'(ccy) - 34'(xy);
          sq_ret <= S_CA;
          state  <= S_SQA;
        end
        S_CA: begin
          ca     <= sum2;
          ea     <= 34'(ccx) - 34'(px);
          eb     <= 34'(ccy) - 34'(py);
          sq_ret <= S_CB;
          state  <= S_SQA;
        end
        S_CB: begin
          dneg   <= (ca <= sum2);
          ea     <= 34'(px);
          eb     <= 34'(py);
          sq_ret <= S_RT;
          rt_ret <= S_PL;
          state  <= S_SQA;
        end
        S_PL: begin
          plen  <= rt_root;
          s     <= '0;
          state <= (prv == '0) ? S_FIN : S_SRD0;
        end
        S_SRD0: state <= S_SLD0;
        S_SLD0: begin
          lastx <= rd_x;
          lasty <= rd_y;
          k     <= CW'(1);
          state <= S_SRD;
        end
        S_SRD: state <= S_SLD;
        S_SLD: begin
          ea     <= 34'(c2f_pkg::sat_diff(rd_x, lastx));
          eb     <= 34'(c2f_pkg::sat_diff(rd_y, lasty));
          lastx  <= rd_x;
          lasty  <= rd_y;
          sq_ret <= S_RT;
          rt_ret <= S_SACC;
          state  <= S_SQA;
        end
        S_SACC: begin
          s <= (s_acc_c > 41'(c2f_pkg::S_MAX)) ? c2f_pkg::S_MAX : 40'(s_acc_c);
          if (k == prv) begin
            state <= S_FIN;
          end else begin
            k     <= CW'(k + CW'(1));
            state <= S_SRD;
          end
        end
        S_FIN: begin
          result.path_s     <= (s_fin_c > 41'(c2f_pkg::S_MAX)) ? c2f_pkg::S_MAX
                                                               : 40'(s_fin_c);
          result.lateral_d  <= dneg ? -$signed(40'(dlen)) : $signed(40'(dlen));
          result.next_index <= 8'(nxt);
          result.prev_index <= 8'(prv);
          done              <= 1'b1;
          state             <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `C2F_ASSERT_NEXT(a_done_after_fin, state == S_FIN, done, "result strobe missing")
  `C2F_ASSERT(a_write_idle, ram_we |-> (state == S_IDLE), "table write while busy")
  `C2F_ASSERT_NEXT(a_query_busy, query_go, busy, "query beat did not start work")
  `C2F_ASSERT(a_div_rem, (state == S_DIV) |-> (dv_rem < 61'(nn)), "divider overflow")
  `C2F_ASSERT(a_best_range, (state == S_BRD) |-> (best_idx < cnt), "nearest index out of range")

endmodule
